@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Each macro expects clk and rst_n to exist in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define WCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define WCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/wcu_pkg.sv @@
`default_nettype none
package wcu_pkg;

  localparam int UNIT_W = 32;
  localparam int CP_W   = 21;
  localparam int BYTE_W = 8;
  localparam int SURR_W = 10;

  // Code point limits and surrogate ranges
  localparam logic [UNIT_W-1:0] MAX_CP     = 32'h0010_FFFF;
  localparam logic [UNIT_W-1:0] HIGH_FIRST = 32'h0000_D800;
  localparam logic [UNIT_W-1:0] HIGH_LAST  = 32'h0000_DBFF;
  localparam logic [UNIT_W-1:0] LOW_FIRST  = 32'h0000_DC00;
  localparam logic [UNIT_W-1:0] LOW_LAST   = 32'h0000_DFFF;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00_FFFD;
  localparam logic [CP_W-1:0] SUPP_BASE   = 21'h01_0000;

  // Encoded length thresholds
  localparam logic [CP_W-1:0] LIM_1B = 21'h00_0080;
  localparam logic [CP_W-1:0] LIM_2B = 21'h00_0800;
  localparam logic [CP_W-1:0] LIM_3B = 21'h01_0000;

  // Lead and continuation byte markers
  localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;

  // Replacement character takes three bytes
  localparam logic [2:0] REPL_LEN = 3'd3;

  // One queued job: optional U+FFFD prefix, then optional code point
  typedef struct packed {
    logic            pre_fffd;
    logic            has_cp;
    logic [CP_W-1:0] cp;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/wcu_if.sv @@
`default_nettype none
// Input channel: one wide code unit per transfer
interface wcu_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcu_pkg::UNIT_W-1:0]  code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

// Output channel: one UTF-8 byte per transfer
interface wcu_out_if;
  logic                        valid;
  logic                        ready;
  logic [wcu_pkg::BYTE_W-1:0]  out_byte;
  logic                        run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

@@ rtl/wcu_front.sv @@
`default_nettype none
module wcu_front (
  input  logic           clk,
  input  logic           rst_n,
  wcu_in_if.sink         in_chan,
  output logic           push_valid,
  input  logic           push_ready,
  output wcu_pkg::cmd_t  push_cmd
);

  logic                        pending_r, pending_nxt;
  logic [wcu_pkg::SURR_W-1:0]  held_r, held_nxt;

  logic [wcu_pkg::UNIT_W-1:0]  u;
  logic                        is_high, is_low, is_zero, xfer;
  wcu_pkg::cmd_t               cmd;

  assign u       = in_chan.code_unit;
  assign is_high = (u >= wcu_pkg::HIGH_FIRST) && (u <= wcu_pkg::HIGH_LAST);
  assign is_low  = (u >= wcu_pkg::LOW_FIRST) && (u <= wcu_pkg::LOW_LAST);
  assign is_zero = (u == '0);

  // Take a unit whenever the queue has room
  assign in_chan.ready = push_ready;
  assign xfer          = in_chan.valid && push_ready;

  // Classify the unit against the held surrogate
  always_comb begin
    cmd         = '0;
    pending_nxt = pending_r;
    held_nxt    = held_r;
    if (pending_r && is_low) begin
      // surrogate pair -> supplementary code point
      cmd.has_cp  = 1'b1;
      cmd.cp      = wcu_pkg::SUPP_BASE + {1'b0, held_r, u[wcu_pkg::SURR_W-1:0]};
      pending_nxt = 1'b0;
      held_nxt    = '0;
    end else begin
      cmd.pre_fffd = pending_r;
      pending_nxt  = 1'b0;
      held_nxt     = '0;
      if (is_zero) begin
        cmd.has_cp = 1'b0;
      end else if (is_high) begin
        pending_nxt = 1'b1;
        held_nxt    = u[wcu_pkg::SURR_W-1:0];
      end else if (is_low) begin
        cmd.has_cp = 1'b1;
        cmd.cp     = wcu_pkg::REPLACEMENT;
      end else begin
        cmd.has_cp = 1'b1;
        cmd.cp     = (u > wcu_pkg::MAX_CP) ? wcu_pkg::REPLACEMENT
                                           : u[wcu_pkg::CP_W-1:0];
      end
    end
  end

  // Units that emit nothing are not queued
  assign push_valid = xfer && (cmd.pre_fffd || cmd.has_cp);
  assign push_cmd   = cmd;

  // Surrogate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      held_r    <= '0;
    end else if (xfer) begin
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wcu_fifo.sv @@
`default_nettype none
module wcu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  wcu_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output wcu_pkg::cmd_t  pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wcu_pkg::cmd_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slots[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wcu_back.sv @@
`default_nettype none
module wcu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  wcu_pkg::cmd_t  head,
  wcu_out_if.source      out_chan
);

  typedef logic [wcu_pkg::BYTE_W-1:0] byte_t;

  // UTF-8 length of a code point
  function automatic logic [2:0] enc_len(input logic [wcu_pkg::CP_W-1:0] cp);
    logic [2:0] len;
    if (cp < wcu_pkg::LIM_1B) begin
      len = 3'd1;
    end else if (cp < wcu_pkg::LIM_2B) begin
      len = 3'd2;
    end else if (cp < wcu_pkg::LIM_3B) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  // UTF-8 byte k of a code point
  function automatic byte_t enc_byte(input logic [wcu_pkg::CP_W-1:0] cp,
                                     input logic [1:0] k);
    byte_t b;
    b = '0;
    case (enc_len(cp))
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        case (k)
          2'd0:    b = wcu_pkg::LEAD_2B | {3'b000, cp[10:6]};
          default: b = wcu_pkg::CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (k)
          2'd0:    b = wcu_pkg::LEAD_3B | {4'b0000, cp[15:12]};
          2'd1:    b = wcu_pkg::CONT_B | {2'b00, cp[11:6]};
          default: b = wcu_pkg::CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = wcu_pkg::LEAD_4B | {5'b00000, cp[20:18]};
          2'd1:    b = wcu_pkg::CONT_B | {2'b00, cp[17:12]};
          2'd2:    b = wcu_pkg::CONT_B | {2'b00, cp[11:6]};
          default: b = wcu_pkg::CONT_B | {2'b00, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

  logic [2:0]  idx_r, idx_nxt;
  logic        out_valid_r;
  byte_t       out_byte_r;
  logic        out_last_r;

  logic [2:0]  offs, cp_len, total, cp_idx;
  logic        is_last, load;
  byte_t       sel_byte;

  // Byte sequencing over prefix and code point
  always_comb begin
    offs     = head.pre_fffd ? wcu_pkg::REPL_LEN : 3'd0;
    cp_len   = head.has_cp ? enc_len(head.cp) : 3'd0;
    total    = offs + cp_len;
    cp_idx   = idx_r - offs;
    is_last  = (idx_r == total - 3'd1);
    if (idx_r < offs) begin
      sel_byte = enc_byte(wcu_pkg::REPLACEMENT, idx_r[1:0]);
    end else begin
      sel_byte = enc_byte(head.cp, cp_idx[1:0]);
    end
    idx_nxt  = is_last ? 3'd0 : idx_r + 3'd1;
  end

  // Load the output register when it is free or being drained
  assign load      = pop_valid && (!out_valid_r || out_chan.ready);
  assign pop_ready = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      idx_r       <= idx_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_byte;
      out_last_r <= is_last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.run_last = out_last_r;

endmodule
`default_nettype wire

@@ rtl/wide_char_to_utf8_encoder.sv @@
`default_nettype none
// Wide code unit to UTF-8 encoder. Each input transfer carries one 16- or
// 32-bit code unit; the block emits its UTF-8 bytes one per output transfer,
// with run_last set on the final byte a unit causes. Surrogate pairs are
// joined, unpaired surrogates and values above U+10FFFF come out as U+FFFD,
// and a zero unit ends the string (flushing a held high surrogate as U+FFFD).
// A unit that emits nothing produces no output transfer at all. Rate: the
// front accepts one unit per cycle while the QUEUE_DEPTH-entry job queue has
// room; the back's single output byte register sends one byte per cycle while
// the receiver is ready. A unit yields 0 to 7 bytes, 4 at most for a valid
// code point. A job is held in a queue slot, then its bytes in the output register.
// No clearing pass follows reset.
`include "assert_macros.svh"
module wide_char_to_utf8_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  wcu_in_if.sink     in_chan,
  wcu_out_if.source  out_chan
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  wcu_pkg::cmd_t  push_cmd, pop_cmd;

  // Front: classify units, track surrogates
  wcu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Job queue between front and back
  wcu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Back: serialize bytes
  wcu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .head      (pop_cmd),
    .out_chan  (out_chan)
  );

  // Only jobs that emit bytes enter the queue
  `WCU_ASSERT(a_push_nonempty, push_valid |-> (push_cmd.pre_fffd || push_cmd.has_cp), "empty job pushed")

  // Queue head always describes at least one byte
  `WCU_ASSERT(a_head_nonempty, pop_valid |-> (pop_cmd.pre_fffd || pop_cmd.has_cp), "empty job at head")

  // Retiring a job leaves its final byte in the output register
  `WCU_ASSERT(a_pop_last, (pop_valid && pop_ready) |=> (out_chan.valid && out_chan.run_last), "job retired without final byte")

endmodule
`default_nettype wire

@@ tb/sv/utf8_stream_checker.sv @@
module utf8_stream_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [wcu_pkg::UNIT_W-1:0] in_code_unit,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [wcu_pkg::BYTE_W-1:0] out_byte,
  input  logic                       out_run_last,
  output int                         fail_count,
  output int                         bytes_left,
  output int                         bytes_checked,
  output int                         pairs_joined
);

  localparam int UNIT_W = wcu_pkg::UNIT_W;
  localparam int BYTE_W = wcu_pkg::BYTE_W;
  localparam int SURR_W = wcu_pkg::SURR_W;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } utf8_byte_t;

  // Expected bytes, oldest first
  utf8_byte_t        utf8_expected[$];
  // Bytes caused by the unit being predicted
  logic [BYTE_W-1:0] unit_bytes[$];

  // Predictor state
  logic              high_held;
  logic [SURR_W-1:0] held_bits;

  int         errors  = 0;
  int         checked = 0;
  int         joined  = 0;
  utf8_byte_t got;

  // Add one byte to the current unit's bytes
  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    unit_bytes.insert(unit_bytes.size(), b);
  endfunction

  // Append the UTF-8 form of one code point; out of range becomes U+FFFD
  task automatic append_code_point(input logic [UNIT_W-1:0] cp_in);
    logic [UNIT_W-1:0] cp;
    cp = (cp_in > wcu_pkg::MAX_CP) ? UNIT_W'(wcu_pkg::REPLACEMENT) : cp_in;
    if (cp < UNIT_W'(wcu_pkg::LIM_1B)) begin
      add_byte(cp[7:0]);
    end else if (cp < UNIT_W'(wcu_pkg::LIM_2B)) begin
      add_byte(wcu_pkg::LEAD_2B | BYTE_W'(cp >> 6));
      add_byte(wcu_pkg::CONT_B | {2'b00, cp[5:0]});
    end else if (cp < UNIT_W'(wcu_pkg::LIM_3B)) begin
      add_byte(wcu_pkg::LEAD_3B | BYTE_W'(cp >> 12));
      add_byte(wcu_pkg::CONT_B | {2'b00, cp[11:6]});
      add_byte(wcu_pkg::CONT_B | {2'b00, cp[5:0]});
    end else begin
      add_byte(wcu_pkg::LEAD_4B | BYTE_W'(cp >> 18));
      add_byte(wcu_pkg::CONT_B | {2'b00, cp[17:12]});
      add_byte(wcu_pkg::CONT_B | {2'b00, cp[11:6]});
      add_byte(wcu_pkg::CONT_B | {2'b00, cp[5:0]});
    end
  endtask

  // Work out the bytes one accepted unit causes and queue them
  task automatic predict_unit(input logic [UNIT_W-1:0] u);
    logic       is_high;
    logic       is_low;
    logic       paired;
    utf8_byte_t entry;
    is_high = (u >= wcu_pkg::HIGH_FIRST) && (u <= wcu_pkg::HIGH_LAST);
    is_low  = (u >= wcu_pkg::LOW_FIRST) && (u <= wcu_pkg::LOW_LAST);
    paired  = 1'b0;
    unit_bytes.delete();
    // A held high surrogate either joins this low one or is flushed as U+FFFD
    if (high_held) begin
      high_held = 1'b0;
      if (is_low) begin
        append_code_point(UNIT_W'(wcu_pkg::SUPP_BASE) + (UNIT_W'(held_bits) << 10)
                          + (u - wcu_pkg::LOW_FIRST));
        paired = 1'b1;
        joined++;
      end else begin
        append_code_point(UNIT_W'(wcu_pkg::REPLACEMENT));
      end
      held_bits = '0;
    end
    // Zero ends the string and adds nothing of its own
    if (!paired && u != '0) begin
      if (is_high) begin
        high_held = 1'b1;
        held_bits = SURR_W'(u - wcu_pkg::HIGH_FIRST);
      end else if (is_low) begin
        append_code_point(UNIT_W'(wcu_pkg::REPLACEMENT));
      end else begin
        append_code_point(u);
      end
    end
    // Only the final byte of the unit carries run_last
    foreach (unit_bytes[i]) begin
      entry.data = unit_bytes[i];
      entry.last = (i == unit_bytes.size() - 1);
      utf8_expected.insert(utf8_expected.size(), entry);
    end
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      high_held = 1'b0;
      held_bits = '0;
      utf8_expected.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_unit(in_code_unit);
      end
      if (out_valid && out_ready) begin
        if (utf8_expected.size() == 0) begin
          $error("unexpected byte transfer: out_byte %02h run_last %0b", out_byte, out_run_last);
          errors++;
        end else begin
          got = utf8_expected[0];
          utf8_expected.delete(0);
          if (out_byte !== got.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", got.data, out_byte);
            errors++;
          end
          if (out_run_last !== got.last) begin
            $error("run_last mismatch: expected %0b, actual %0b", got.last, out_run_last);
            errors++;
          end
          checked++;
        end
      end
    end
    fail_count    <= errors;
    bytes_left    <= utf8_expected.size();
    bytes_checked <= checked;
    pairs_joined  <= joined;
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;

  logic clk;
  logic rst_n;

  wcu_in_if  in_ch ();
  wcu_out_if out_ch ();

  int fail_count;
  int bytes_left;
  int bytes_checked;
  int pairs_joined;

  // Sender and receiver pacing
  int   units_sent    = 0;
  logic tx_idle_on    = 1'b1;
  logic rx_idle_on    = 1'b1;
  int   hold_requests = 0;

  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = 20;

  localparam logic [wcu_pkg::UNIT_W-1:0] DIRECTED_UNITS [26] = '{
    32'h0000_0000,                 // end of string with nothing held
    32'h0000_007F, 32'h0000_0080,  // one/two byte boundary
    32'h0000_07FF, 32'h0000_0800,  // two/three byte boundary
    32'h0000_D7FF, 32'h0000_E000,  // around the surrogate range
    32'h0000_FFFD, 32'h0000_FFFF,
    32'h0001_0000, 32'h0010_FFFF,  // supplementary plane limits
    32'h0011_0000, 32'hFFFF_FFFF,  // out of range
    32'h0000_D800, 32'h0000_DC00,  // lowest pair
    32'h0000_DBFF, 32'h0000_DFFF,  // highest pair
    32'h0000_DC00,                 // stray low surrogate
    32'h0000_D9A5, 32'h0000_0041,  // unpaired high, then ascii
    32'h0000_DA00, 32'h0000_DB00,  // high replaced by another high
    32'h0000_0000,                 // zero flushes the held high
    32'h0000_DABC, 32'h8000_0000,  // high, then out of range
    32'h0000_DFFF                  // stray low at the top of the range
  };

  wide_char_to_utf8_encoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  utf8_stream_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_code_unit  (in_ch.code_unit),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_run_last  (out_ch.run_last),
    .fail_count    (fail_count),
    .bytes_left    (bytes_left),
    .bytes_checked (bytes_checked),
    .pairs_joined  (pairs_joined)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("wide_char_to_utf8_encoder regression: fail");
    $finish;
  end

  // Offer one unit, keeping valid high when the next follows back to back
  task automatic send_unit(input logic [wcu_pkg::UNIT_W-1:0] u);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_unit <= u;
    do @(posedge clk); while (!in_ch.ready);
    units_sent++;
  endtask

  // Sender pause until every predicted byte has been transferred
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (bytes_left != 0);
  endtask

  // One random character: mostly well formed, some broken sequences and noise
  task automatic send_random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      send_unit($urandom_range(32'h01, 32'h7F));
    end else if (pick < 35) begin
      send_unit($urandom_range(32'h80, 32'h7FF));
    end else if (pick < 50) begin
      if ($urandom_range(0, 1)) send_unit($urandom_range(32'h800, 32'hD7FF));
      else send_unit($urandom_range(32'hE000, 32'hFFFF));
    end else if (pick < 70) begin
      send_unit($urandom_range(wcu_pkg::HIGH_FIRST, wcu_pkg::HIGH_LAST));
      send_unit($urandom_range(wcu_pkg::LOW_FIRST, wcu_pkg::LOW_LAST));
    end else if (pick < 75) begin
      send_unit($urandom_range(32'h1_0000, wcu_pkg::MAX_CP));
    end else if (pick < 80) begin
      send_unit($urandom_range(wcu_pkg::HIGH_FIRST, wcu_pkg::HIGH_LAST));
    end else if (pick < 85) begin
      send_unit($urandom_range(wcu_pkg::LOW_FIRST, wcu_pkg::LOW_LAST));
    end else if (pick < 90) begin
      send_unit('0);
    end else if (pick < 95) begin
      send_unit($urandom_range(wcu_pkg::MAX_CP + 1, 32'hFFFF_FFFF));
    end else begin
      send_unit($urandom());
    end
  endtask

  // Receiver: random stalls per byte, with an occasional long hold-off
  initial begin
    int stall;
    int holds_served;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_requests != holds_served) begin
        stall = HOLD_CYCLES;
        holds_served++;
      end else begin
        stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int goal;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.code_unit <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases
    foreach (DIRECTED_UNITS[i]) send_unit(DIRECTED_UNITS[i]);
    drain_results();

    // Random phases; every third one runs with no idling on either side
    for (int phase = 0; phase < 6; phase++) begin
      tx_idle_on  = (phase % 3 != 1);
      rx_idle_on <= (phase % 3 != 1);
      if (phase == 3) begin
        // Receiver holds off while the sender keeps offering units
        drain_results();
        tx_idle_on     = 1'b0;
        hold_requests <= hold_requests + 1;
      end
      goal = units_sent + 16;
      while (units_sent < goal) send_random_char();
      if (phase == 1) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d code units (corner values, pairs, stray and unpaired surrogates,",
             units_sent);
    $display("  out of range, end of string); %0d bytes checked, %0d surrogate pairs joined.",
             bytes_checked, pairs_joined);
    if (fail_count == 0) begin
      $display("wide_char_to_utf8_encoder regression: pass");
    end else begin
      $display("wide_char_to_utf8_encoder regression: fail");
    end
    $finish;
  end

endmodule
